// ===== hw/rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg: shared codes and types of the range-minimum engine
// Input kinds, result status codes and the command control word that the
// front end hands to the back end.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int KIND_W   = 2;
  localparam int LEFT_W   = 10;
  localparam int RIGHT_W  = 11;
  localparam int COUNT_W  = 11;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;

  // input kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BUILD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BUILT     = 2'd2;

  // classified command
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  typedef struct packed {
    op_t  op;
    logic single;      // one-element range, answered from the leaf
    logic need_right;  // right entry takes part in the answer
  } cmd_ctl_t;

endpackage

// ===== hw/rtl/rmq_ram.sv =====
// ----------------------------------------------------------------------------
// rmq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/rmq_fifo.sv =====
// ----------------------------------------------------------------------------
// rmq_fifo: small register queue
// Holds a few words between two sides that stall independently.
// ----------------------------------------------------------------------------
module rmq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wr_data,
  output logic             empty,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front: intake and classification
// Checks query ranges, finds the table level, and queues commands.
// ----------------------------------------------------------------------------
module rmq_front #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_BITS  = 32,
  parameter int QUEUE_DEPTH = 2,
  localparam int AW  = $clog2(DEPTH),
  localparam int LW  = (AW > 1) ? $clog2(AW) : 1,
  localparam int IW  = (AW + 1 > rmq_pkg::COUNT_W) ? AW + 1 : rmq_pkg::COUNT_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [rmq_pkg::KIND_W-1:0]   kind,
  input  logic [rmq_pkg::LEFT_W-1:0]   left_index,
  input  logic [rmq_pkg::RIGHT_W-1:0]  right_end,
  input  logic signed [rmq_pkg::WORD_W-1:0] element_value,
  input  logic [IW-1:0]                count,
  output logic                         cmd_valid,
  input  logic                         cmd_pop,
  output rmq_pkg::cmd_ctl_t            cmd_ctl,
  output logic [AW-1:0]                cmd_left,
  output logic [AW-1:0]                cmd_last,
  output logic [LW-1:0]                cmd_lvl,
  output logic [VALUE_BITS-1:0]        cmd_value
);

  typedef struct packed {
    rmq_pkg::cmd_ctl_t     ctl;
    logic [AW-1:0]         left;
    logic [AW-1:0]         last;
    logic [LW-1:0]         lvl;
    logic [VALUE_BITS-1:0] value;
  } cmd_t;

  cmd_t          in_cmd;
  cmd_t          head;
  logic          keep;
  logic          q_full;
  logic          q_empty;
  logic [IW-1:0] left_w;
  logic [IW-1:0] right_w;
  logic [IW-1:0] last_w;
  logic [AW-1:0] diff;

  always_comb begin
    left_w = IW'(left_index);
    right_w = IW'(right_end);
    last_w = right_w - IW'(1);
    in_cmd.left = left_w[AW-1:0];
    in_cmd.last = last_w[AW-1:0];
    in_cmd.value = VALUE_BITS'(element_value);
    diff = in_cmd.left ^ in_cmd.last;

    // level = top set bit of left ^ last
    in_cmd.lvl = '0;
    for (int b = 0; b < AW; b++) begin
      if (diff[b]) begin
        in_cmd.lvl = LW'(b);
      end
    end

    // right entry needed unless last sits on the block midpoint
    in_cmd.ctl.need_right = 1'b0;
    for (int b = 0; b < AW; b++) begin
      if (b < int'(in_cmd.lvl) && in_cmd.last[b]) begin
        in_cmd.ctl.need_right = 1'b1;
      end
    end
    in_cmd.ctl.single = (in_cmd.left == in_cmd.last);

    keep = 1'b1;
    in_cmd.ctl.op = rmq_pkg::OP_BAD;
    case (kind)
      rmq_pkg::KIND_LOAD: begin
        in_cmd.ctl.op = rmq_pkg::OP_LOAD;
        keep = (left_w < IW'(DEPTH));
      end
      rmq_pkg::KIND_BUILD: begin
        in_cmd.ctl.op = rmq_pkg::OP_BUILD;
      end
      rmq_pkg::KIND_QUERY: begin
        in_cmd.ctl.op = (right_w <= left_w || right_w > count) ? rmq_pkg::OP_BAD
                                                               : rmq_pkg::OP_QUERY;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  rmq_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .push    (push && !q_full && keep),
    .full    (q_full),
    .wr_data (in_cmd),
    .empty   (q_empty),
    .pop     (cmd_pop),
    .rd_data (head)
  );

  assign full      = q_full;
  assign cmd_valid = !q_empty;
  assign cmd_ctl   = head.ctl;
  assign cmd_left  = head.left;
  assign cmd_last  = head.last;
  assign cmd_lvl   = head.lvl;
  assign cmd_value = head.value;

endmodule

// ===== hw/rtl/rmq_back.sv =====
// ----------------------------------------------------------------------------
// rmq_back: command execution
// Leaf store, two-bank level table, build sweep and query lookup.
// ----------------------------------------------------------------------------
module rmq_back #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32,
  localparam int AW  = $clog2(DEPTH),
  localparam int LW  = (AW > 1) ? $clog2(AW) : 1,
  localparam int IW  = (AW + 1 > rmq_pkg::COUNT_W) ? AW + 1 : rmq_pkg::COUNT_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [IW-1:0]                  count,
  input  logic                           cmd_valid,
  output logic                           cmd_pop,
  input  rmq_pkg::cmd_ctl_t              cmd_ctl,
  input  logic [AW-1:0]                  cmd_left,
  input  logic [AW-1:0]                  cmd_last,
  input  logic [LW-1:0]                  cmd_lvl,
  input  logic [VALUE_BITS-1:0]          cmd_value,
  input  logic                           res_room,
  output logic                           res_push,
  output logic [rmq_pkg::WORD_W-1:0]     res_min,
  output logic [rmq_pkg::STATUS_W-1:0]   res_status
);

  localparam int LEVELS = AW;
  localparam int XW     = AW + 1;
  localparam int SH     = AW - 1;
  localparam int HALF   = 1 << SH;
  localparam int BI_W   = (AW > 1) ? AW - 1 : 1;
  localparam int BANK_DEPTH = LEVELS * HALF;
  localparam int TA_W   = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_QUERY = 4'b0010,
    ST_BUILD = 4'b0100,
    ST_BLAST = 4'b1000
  } state_t;

  // bank address: level row, index with the level bit dropped
  function automatic logic [TA_W-1:0] taddr(input logic [LW-1:0] lvl,
                                            input logic [AW-1:0] idx);
    logic [AW:0]     ext;
    logic [BI_W-1:0] bidx;
    ext = {1'b0, idx};
    for (int b = 0; b < BI_W; b++) begin
      bidx[b] = (b < int'(lvl)) ? ext[b] : ext[b + 1];
    end
    return (TA_W'(lvl) << SH) | TA_W'(bidx);
  endfunction

  state_t state;
  state_t state_next;

  // build sweep counters
  logic [AW-1:0] b_ctr;
  logic [AW-1:0] b_ctr_next;
  logic [LW-1:0] b_lvl;
  logic [LW-1:0] b_lvl_next;
  logic [XW-1:0] h;
  logic [XW-1:0] m2;
  logic [XW-1:0] j;
  logic [XW-1:0] base;
  logic [XW-1:0] idx_w;
  logic [AW-1:0] b_idx;
  logic          b_first;
  logic          b_pad;
  logic          issue;

  // build write stage
  logic                         p_valid;
  logic [AW-1:0]                p_idx;
  logic [LW-1:0]                p_lvl;
  logic                         p_first;
  logic                         p_pad;
  logic signed [VALUE_BITS-1:0] d;
  logic signed [VALUE_BITS-1:0] run;
  logic signed [VALUE_BITS-1:0] run_next;
  logic [TA_W-1:0]              wr_taddr;

  // query
  logic                         q_single;
  logic                         q_single_next;
  logic                         q_nr;
  logic                         q_nr_next;
  logic signed [VALUE_BITS-1:0] q_ans;

  // memories
  logic                  leaf_we;
  logic [AW-1:0]         leaf_rd_addr;
  logic [VALUE_BITS-1:0] leaf_rd;
  logic [VALUE_BITS-1:0] b0_rd;
  logic [VALUE_BITS-1:0] b1_rd;

  // -------- build index generation --------
  always_comb begin
    h     = XW'(1) << b_lvl;
    m2    = (XW'(2) << b_lvl) - XW'(1);
    j     = {1'b0, b_ctr} & m2;
    base  = {1'b0, b_ctr} & ~m2;
    if (j <= h) begin
      idx_w = base | (h - j);   // leftward from the midpoint
    end else begin
      idx_w = base | j;         // rightward from midpoint + 1
    end
    b_idx   = idx_w[AW-1:0];
    b_first = (j == '0) || (j == h + XW'(1));
    b_pad   = (IW'(b_idx) >= count);
  end

  // -------- running minimum --------
  always_comb begin
    d = p_pad ? VALUE_MAX : leaf_rd;
    run_next = (p_first || d < run) ? d : run;
    wr_taddr = taddr(p_lvl, p_idx);
  end

  assign q_ans = q_single ? signed'(leaf_rd)
               : ((q_nr && signed'(b1_rd) < signed'(b0_rd)) ? signed'(b1_rd)
                                                            : signed'(b0_rd));

  // -------- control --------
  always_comb begin
    state_next    = state;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res_min       = '0;
    res_status    = rmq_pkg::STATUS_OK;
    leaf_we       = 1'b0;
    leaf_rd_addr  = cmd_left;
    issue         = 1'b0;
    b_ctr_next    = b_ctr;
    b_lvl_next    = b_lvl;
    q_single_next = q_single;
    q_nr_next     = q_nr;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd_ctl.op)
            rmq_pkg::OP_LOAD: begin
              leaf_we = 1'b1;
              cmd_pop = 1'b1;
            end
            rmq_pkg::OP_BAD: begin
              if (res_room) begin
                cmd_pop    = 1'b1;
                res_push   = 1'b1;
                res_status = rmq_pkg::STATUS_BAD_RANGE;
              end
            end
            rmq_pkg::OP_QUERY: begin
              if (res_room) begin
                cmd_pop       = 1'b1;
                q_single_next = cmd_ctl.single;
                q_nr_next     = cmd_ctl.need_right;
                state_next    = ST_QUERY;
              end
            end
            rmq_pkg::OP_BUILD: begin
              if (res_room) begin
                cmd_pop    = 1'b1;
                b_ctr_next = '0;
                b_lvl_next = '0;
                state_next = ST_BUILD;
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      ST_QUERY: begin
        res_push   = 1'b1;
        res_min    = rmq_pkg::WORD_W'(q_ans);
        state_next = ST_IDLE;
      end
      ST_BUILD: begin
        issue        = 1'b1;
        leaf_rd_addr = b_idx;
        b_ctr_next   = b_ctr + AW'(1);
        if (&b_ctr) begin
          if (b_lvl == LW'(LEVELS - 1)) begin
            state_next = ST_BLAST;
          end else begin
            b_lvl_next = b_lvl + LW'(1);
          end
        end
      end
      ST_BLAST: begin
        res_push   = 1'b1;
        res_status = rmq_pkg::STATUS_BUILT;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      p_valid <= 1'b0;
    end else begin
      state   <= state_next;
      p_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    b_ctr    <= b_ctr_next;
    b_lvl    <= b_lvl_next;
    q_single <= q_single_next;
    q_nr     <= q_nr_next;
    p_idx    <= b_idx;
    p_lvl    <= b_lvl;
    p_first  <= b_first;
    p_pad    <= b_pad;
    if (p_valid) begin
      run <= run_next;
    end
  end

  rmq_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(DEPTH)
  ) u_leaf (
    .clk     (clk),
    .wr_en   (leaf_we),
    .wr_addr (cmd_left),
    .wr_data (cmd_value),
    .rd_addr (leaf_rd_addr),
    .rd_data (leaf_rd)
  );

  // bank 0 holds entries whose level bit is clear, bank 1 those with it set
  rmq_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(BANK_DEPTH)
  ) u_bank0 (
    .clk     (clk),
    .wr_en   (p_valid && !p_idx[p_lvl]),
    .wr_addr (wr_taddr),
    .wr_data (run_next),
    .rd_addr (taddr(cmd_lvl, cmd_left)),
    .rd_data (b0_rd)
  );

  rmq_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(BANK_DEPTH)
  ) u_bank1 (
    .clk     (clk),
    .wr_en   (p_valid && p_idx[p_lvl]),
    .wr_addr (wr_taddr),
    .wr_data (run_next),
    .rd_addr (taddr(cmd_lvl, cmd_last)),
    .rd_data (b1_rd)
  );

  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res_room)
    else $error("result pushed with no room reserved");

  a_query_dispatch: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QUERY) |-> $past(cmd_pop && cmd_ctl.op == rmq_pkg::OP_QUERY))
    else $error("query lookup without a dispatched query");

  a_build_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BUILD) |-> !cmd_pop)
    else $error("command taken during build sweep");

  a_pipe_src: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> $past(state == ST_BUILD))
    else $error("table write without a build read");

  a_last_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BLAST) |-> p_valid)
    else $error("build reported before final table write");

endmodule

// ===== hw/rtl/range_minimum_query_engine_core.sv =====
// ----------------------------------------------------------------------------
// range_minimum_query_engine_core: range-minimum engine, disjoint sparse table
// Loads leaves, builds every table level, and answers half-open range queries
// from at most two table reads.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    word
//  --------  ---------  ---------------------------  --------------------------
//  input     in         push / full                  kind, left_index,
//                                                    right_end, element_value
//  result    out        empty / pop                  minimum_value, status
//  config    in         config_write (no wait)       config_data -> element_count
//
//  Flow: a word is classified as it is pushed and enters a two-word command
//  queue. The back end then handles a load or a bad range straight from idle,
//  a query by reading both table banks together and then doing one compare,
//  and a build as a sweep over every table level (one leaf read and one table
//  write per cycle) followed by a report step. LEVELS = ceil(log2(DEPTH)).
//  Reset: element_count returns to DEPTH; queues empty; memories hold no
//  reset value and need no clearing pass.
//  Stalls: a full command queue raises full; a full two-word result queue
//  holds back only commands that report, loads still go ahead.
//
module range_minimum_query_engine_core #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // input word
  input  logic                              push,
  output logic                              full,
  input  logic [rmq_pkg::KIND_W-1:0]        kind,
  input  logic [rmq_pkg::LEFT_W-1:0]        left_index,
  input  logic [rmq_pkg::RIGHT_W-1:0]       right_end,
  input  logic signed [rmq_pkg::WORD_W-1:0] element_value,
  // result word
  output logic                              empty,
  input  logic                              pop,
  output logic signed [rmq_pkg::WORD_W-1:0] minimum_value,
  output logic [rmq_pkg::STATUS_W-1:0]      status,
  // element_count register
  input  logic                              config_write,
  input  logic [rmq_pkg::COUNT_W-1:0]       config_data
);

  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = (AW > 1) ? $clog2(AW) : 1;
  localparam int IW    = (AW + 1 > rmq_pkg::COUNT_W) ? AW + 1 : rmq_pkg::COUNT_W;
  localparam int RES_W = rmq_pkg::WORD_W + rmq_pkg::STATUS_W;

  // element_count, saturated to DEPTH on write
  logic [IW-1:0] count;
  logic [IW-1:0] cfg_ext;

  assign cfg_ext = IW'(config_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= IW'(DEPTH);
    end else if (config_write) begin
      count <= (cfg_ext > IW'(DEPTH)) ? IW'(DEPTH) : cfg_ext;
    end
  end

  // front end to back end
  logic                  cmd_valid;
  logic                  cmd_pop;
  rmq_pkg::cmd_ctl_t     cmd_ctl;
  logic [AW-1:0]         cmd_left;
  logic [AW-1:0]         cmd_last;
  logic [LW-1:0]         cmd_lvl;
  logic [VALUE_BITS-1:0] cmd_value;

  // back end to result queue
  logic                           res_full;
  logic                           res_push;
  logic [rmq_pkg::WORD_W-1:0]     res_min;
  logic [rmq_pkg::STATUS_W-1:0]   res_status;
  logic [RES_W-1:0]               res_word;

  rmq_front #(
    .DEPTH       (DEPTH),
    .VALUE_BITS  (VALUE_BITS),
    .QUEUE_DEPTH (2)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .kind          (kind),
    .left_index    (left_index),
    .right_end     (right_end),
    .element_value (element_value),
    .count         (count),
    .cmd_valid     (cmd_valid),
    .cmd_pop       (cmd_pop),
    .cmd_ctl       (cmd_ctl),
    .cmd_left      (cmd_left),
    .cmd_last      (cmd_last),
    .cmd_lvl       (cmd_lvl),
    .cmd_value     (cmd_value)
  );

  rmq_back #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .count      (count),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd_ctl    (cmd_ctl),
    .cmd_left   (cmd_left),
    .cmd_last   (cmd_last),
    .cmd_lvl    (cmd_lvl),
    .cmd_value  (cmd_value),
    .res_room   (!res_full),
    .res_push   (res_push),
    .res_min    (res_min),
    .res_status (res_status)
  );

  // result queue parts the back end from the consumer
  rmq_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .full    (res_full),
    .wr_data ({res_min, res_status}),
    .empty   (empty),
    .pop     (pop),
    .rd_data (res_word)
  );

  assign minimum_value = res_word[RES_W-1:rmq_pkg::STATUS_W];
  assign status        = res_word[rmq_pkg::STATUS_W-1:0];

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the range-minimum query engine
// Keeps its own copy of the leaves and of every sparse-table level, predicts
// the result word of each accepted build or query and checks it against the DUT
// in order. A directed part walks register extremes, block edges and stale
// tables, then random phases vary the element count with random handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  // unused kind: the engine drops it without a result
  localparam logic [rmq_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int unsigned SPAN   = 1024;  // leaf array and table width
  localparam int unsigned LEVELS = 10;    // log2(SPAN)
  localparam int unsigned SETTLE = 16;    // cycles for loads still in the queues

  localparam logic signed [rmq_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [rmq_pkg::WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic signed [rmq_pkg::WORD_W-1:0] value;
    logic [rmq_pkg::STATUS_W-1:0]      status;
  } result_t;

  // DUT signals; the inputs are all known from time zero
  logic                              clk;
  logic                              rst           = 1'b1;
  logic                              push          = 1'b0;
  logic                              full;
  logic [rmq_pkg::KIND_W-1:0]        kind          = rmq_pkg::KIND_LOAD;
  logic [rmq_pkg::LEFT_W-1:0]        left_index    = '0;
  logic [rmq_pkg::RIGHT_W-1:0]       right_end     = '0;
  logic signed [rmq_pkg::WORD_W-1:0] element_value = '0;
  logic                              empty;
  logic                              pop           = 1'b0;
  logic signed [rmq_pkg::WORD_W-1:0] minimum_value;
  logic [rmq_pkg::STATUS_W-1:0]      status;
  logic                              config_write  = 1'b0;
  logic [rmq_pkg::COUNT_W-1:0]       config_data   = '0;

  // predictor state: leaves, table levels and the element_count register
  logic signed [rmq_pkg::WORD_W-1:0] leaf_copy [SPAN];
  bit                                leaf_known [SPAN];
  logic signed [rmq_pkg::WORD_W-1:0] sparse_rows [LEVELS][SPAN];
  int unsigned                       elem_count = SPAN;

  result_t awaited_results [$];

  // handshake pacing
  bit quiet_send = 1'b0;
  bit quiet_recv = 1'b0;
  int pop_hold   = 0;

  // run statistics
  int unsigned fault_count    = 0;
  int unsigned items_sent     = 0;
  int unsigned loads_done     = 0;
  int unsigned builds_done    = 0;
  int unsigned answered       = 0;
  int unsigned refused        = 0;
  int unsigned ignored        = 0;
  int unsigned count_settings = 0;

  range_minimum_query_engine_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .kind          (kind),
    .left_index    (left_index),
    .right_end     (right_end),
    .element_value (element_value),
    .empty         (empty),
    .pop           (pop),
    .minimum_value (minimum_value),
    .status        (status),
    .config_write  (config_write),
    .config_data   (config_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop well beyond the slowest correct run (builds dominate)
  initial begin
    #(100_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic logic signed [rmq_pkg::WORD_W-1:0] lesser(
      logic signed [rmq_pkg::WORD_W-1:0] a, logic signed [rmq_pkg::WORD_W-1:0] b);
    return (b < a) ? b : a;
  endfunction

  // positions at or past the count read as the largest value during a build
  function automatic logic signed [rmq_pkg::WORD_W-1:0] padded_leaf(int unsigned i);
    return (i < elem_count) ? leaf_copy[i] : WORD_MAX;
  endfunction

  // each level k: blocks of 2^(k+1), running minima out from the midpoint
  function automatic void rebuild_rows();
    int unsigned k, half, base, mid, stop, i;
    logic signed [rmq_pkg::WORD_W-1:0] run;
    for (k = 0; k < LEVELS; k++) begin
      half = 1 << k;
      for (base = 0; base + 2 * half <= SPAN; base += 2 * half) begin
        mid  = base + half;
        stop = base + 2 * half;
        // leftward half includes the midpoint itself
        run = padded_leaf(mid);
        sparse_rows[k][mid] = run;
        for (i = mid; i > base; i--) begin
          run = lesser(run, padded_leaf(i - 1));
          sparse_rows[k][i - 1] = run;
        end
        // rightward half starts one past the midpoint
        if (mid + 1 < stop) begin
          run = padded_leaf(mid + 1);
          sparse_rows[k][mid + 1] = run;
          for (i = mid + 2; i < stop; i++) begin
            run = lesser(run, padded_leaf(i));
            sparse_rows[k][i] = run;
          end
        end
      end
    end
  endfunction

  function automatic result_t range_minimum(int unsigned lo, int unsigned hi);
    result_t     r;
    int unsigned last, x, k;
    r.value  = '0;
    r.status = rmq_pkg::STATUS_OK;
    if (hi <= lo || hi > elem_count) begin
      r.status = rmq_pkg::STATUS_BAD_RANGE;
      return r;
    end
    last = hi - 1;
    if (last == lo) begin
      r.value = leaf_copy[lo];
    end else begin
      x = lo ^ last;
      k = 0;
      while ((x >> (k + 1)) != 0) k++;
      r.value = sparse_rows[k][lo];
      // right entry only when the range does not stop on the midpoint
      if ((last & ((1 << k) - 1)) != 0)
        r.value = lesser(r.value, sparse_rows[k][last]);
    end
    return r;
  endfunction

  // update the copy for one accepted word and queue what it should return
  function automatic void track_word(logic [rmq_pkg::KIND_W-1:0] k,
                                     logic [rmq_pkg::LEFT_W-1:0] lo,
                                     logic [rmq_pkg::RIGHT_W-1:0] hi,
                                     logic signed [rmq_pkg::WORD_W-1:0] v);
    result_t r;
    case (k)
      rmq_pkg::KIND_LOAD: begin
        leaf_copy[lo]  = v;
        leaf_known[lo] = 1'b1;
        loads_done++;
      end
      rmq_pkg::KIND_BUILD: begin
        rebuild_rows();
        r.value  = '0;
        r.status = rmq_pkg::STATUS_BUILT;
        awaited_results.push_back(r);
        builds_done++;
      end
      rmq_pkg::KIND_QUERY: begin
        r = range_minimum(32'(lo), 32'(hi));
        awaited_results.push_back(r);
        if (r.status == rmq_pkg::STATUS_OK) answered++;
        else refused++;
      end
      default: ignored++;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: pop pacing and in-order checking
  // --------------------------------------------------------------------------

  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold = pop_hold - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && pop && !empty) begin
      if (awaited_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("[%0t] unexpected result word: minimum %0d status %0d",
                   $realtime, minimum_value, status);
      end else begin
        want = awaited_results.pop_front();
        if (minimum_value !== want.value || status !== want.status) begin
          fault_count++;
          if (fault_count <= 10)
            $display("[%0t] mismatch: minimum exp %0d got %0d, status exp %0d got %0d",
                     $realtime, want.value, minimum_value, want.status, status);
        end
      end
      pop_hold = quiet_recv ? 0 : $urandom_range(0, 6);
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // one word through push/full, with a random gap in front of it
  task automatic send_word(logic [rmq_pkg::KIND_W-1:0] k, int unsigned lo,
                           int unsigned hi, logic signed [rmq_pkg::WORD_W-1:0] v);
    int unsigned                 gap;
    logic [rmq_pkg::LEFT_W-1:0]  lo_w;
    logic [rmq_pkg::RIGHT_W-1:0] hi_w;
    lo_w = rmq_pkg::LEFT_W'(lo);
    hi_w = rmq_pkg::RIGHT_W'(hi);
    gap = quiet_send ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push          <= 1'b1;
    kind          <= k;
    left_index    <= lo_w;
    right_end     <= hi_w;
    element_value <= v;
    do @(posedge clk); while (full);
    track_word(k, lo_w, hi_w, v);
    if (k != KIND_UNUSED) items_sent++;
  endtask

  // stop sending and wait for every awaited result, plus slack for loads
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // element_count is only written with the engine idle
  task automatic write_count(int unsigned raw);
    settle();
    @(negedge clk);
    config_write <= 1'b1;
    config_data  <= rmq_pkg::COUNT_W'(raw);
    @(negedge clk);
    config_write <= 1'b0;
    elem_count = (raw > SPAN) ? SPAN : raw;
    count_settings++;
  endtask

  function automatic logic signed [rmq_pkg::WORD_W-1:0] pick_value();
    logic signed [rmq_pkg::WORD_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = WORD_MIN;
      1: v = WORD_MAX;
      2, 3: begin
        // narrow band so that ties turn up
        v = $urandom_range(0, 15);
        v = v - 8;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // count at its reset value and saturated; no table yet, so only bad ranges
  task automatic test_register_extremes();
    send_word(rmq_pkg::KIND_QUERY, 5, 5, 32'sd0);      // empty range
    send_word(rmq_pkg::KIND_QUERY, 9, 3, -32'sd1);     // reversed range
    send_word(KIND_UNUSED, 1023, 2047, WORD_MIN);
    write_count(2047);                                 // saturates to DEPTH
    send_word(rmq_pkg::KIND_QUERY, 700, 600, WORD_MAX);
  endtask

  // smallest table: one element in use
  task automatic test_single_element();
    write_count(1);
    send_word(rmq_pkg::KIND_LOAD, 0, 1, WORD_MIN);
    send_word(rmq_pkg::KIND_LOAD, 1023, 1024, WORD_MAX);
    send_word(rmq_pkg::KIND_BUILD, 0, 0, 32'sd0);
    send_word(rmq_pkg::KIND_QUERY, 0, 1, 32'sd0);
    send_word(rmq_pkg::KIND_QUERY, 0, 2, 32'sd0);      // one past the count
  endtask

  // eight leaves: midpoint stops, single leaf, full span, past the count
  task automatic test_block_edges();
    logic signed [rmq_pkg::WORD_W-1:0] vals [8];
    int unsigned i;
    vals = '{32'sd7, -32'sd1, 32'sd0, WORD_MAX, -32'sd3, 32'sd1, WORD_MIN + 1, 32'sd2};
    write_count(8);
    for (i = 0; i < 8; i++) send_word(rmq_pkg::KIND_LOAD, i, 1, vals[i]);
    send_word(rmq_pkg::KIND_BUILD, 3, 7, 32'sd0);
    send_word(rmq_pkg::KIND_QUERY, 0, 8, 32'sd0);
    send_word(rmq_pkg::KIND_QUERY, 2, 4, 32'sd0);      // ends on the level-0 midpoint
    send_word(rmq_pkg::KIND_QUERY, 3, 4, 32'sd0);
    send_word(rmq_pkg::KIND_QUERY, 1, 7, 32'sd0);
    send_word(rmq_pkg::KIND_QUERY, 4, 9, 32'sd0);
  endtask

  // loads and a count change after the build: table answers go stale,
  // single leaves do not
  task automatic test_stale_table();
    send_word(rmq_pkg::KIND_LOAD, 3, 1, -32'sd100);
    send_word(rmq_pkg::KIND_QUERY, 3, 4, 32'sd0);
    send_word(rmq_pkg::KIND_QUERY, 0, 8, 32'sd0);
    write_count(1024);
    send_word(rmq_pkg::KIND_QUERY, 0, 1024, 32'sd0);
    send_word(rmq_pkg::KIND_QUERY, 1023, 1024, 32'sd0);
    send_word(rmq_pkg::KIND_QUERY, 6, 1024, 32'sd0);
    send_word(rmq_pkg::KIND_QUERY, 0, 513, 32'sd0);    // stops on the top midpoint
  endtask

  // phases of random traffic, each under its own element count
  task automatic test_random_traffic(int unsigned target);
    int unsigned cnt, raw, n, i, pick, lo, hi;
    bit fresh_build, extra_done;
    while (items_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) raw = 1;
      else if (pick < 7) raw = $urandom_range(2, 48);
      else if (pick < 9) raw = $urandom_range(49, 160);
      else raw = $urandom_range(1024, 2047);
      quiet_send = ($urandom_range(0, 3) == 0);
      quiet_recv = ($urandom_range(0, 3) == 0);
      write_count(raw);
      cnt = elem_count;

      // a build needs every leaf below the count loaded first
      fresh_build = (cnt <= 160) && ($urandom_range(0, 3) != 0);
      if (fresh_build) begin
        for (i = 0; i < cnt; i++)
          if (!leaf_known[i] || $urandom_range(0, 7) == 0)
            send_word(rmq_pkg::KIND_LOAD, i, $urandom_range(1, 1024), pick_value());
        send_word(rmq_pkg::KIND_BUILD, $urandom_range(0, 1023), $urandom_range(1, 1024),
                  $urandom());
      end

      extra_done = 1'b0;
      n = $urandom_range(25, 50);
      for (i = 0; i < n && items_sent < target; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // well-formed query
          if (cnt >= 2 && $urandom_range(0, 3) != 0) begin
            lo = $urandom_range(0, cnt - 2);
            hi = $urandom_range(lo + 2, cnt);
          end else begin
            lo = $urandom_range(0, cnt - 1);
            if (!leaf_known[lo]) lo = 0;
            hi = lo + 1;
          end
          send_word(rmq_pkg::KIND_QUERY, lo, hi, $urandom());
        end else if (pick < 75) begin
          lo = (pick < 70) ? $urandom_range(0, cnt - 1) : $urandom_range(0, 1023);
          send_word(rmq_pkg::KIND_LOAD, lo, $urandom_range(1, 1024), pick_value());
        end else if (pick < 88) begin
          // broken query: empty, reversed or past the count
          case ($urandom_range(0, 2))
            0: begin
              lo = $urandom_range(1, 1023);
              hi = lo;
            end
            1: begin
              lo = $urandom_range(1, 1023);
              hi = $urandom_range(1, lo);
            end
            default: begin
              if (cnt < SPAN) begin
                hi = $urandom_range(cnt + 1, SPAN);
                lo = $urandom_range(0, hi - 1);
              end else begin
                lo = $urandom_range(1, 1023);
                hi = $urandom_range(1, lo);
              end
            end
          endcase
          send_word(rmq_pkg::KIND_QUERY, lo, hi, $urandom());
        end else if (pick < 93) begin
          send_word(KIND_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 2047), $urandom());
        end else if (pick < 96) begin
          if (fresh_build && !extra_done) begin
            send_word(rmq_pkg::KIND_BUILD, $urandom_range(0, 1023), $urandom_range(1, 1024),
                      $urandom());
            extra_done = 1'b1;
          end
        end else begin
          settle();  // sender holds off until the result queue has drained
        end
      end
    end
    quiet_send = 1'b0;
    quiet_recv = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_extremes();
    test_single_element();
    test_block_edges();
    test_stale_table();
    test_random_traffic(450);

    settle();
    repeat (32) @(posedge clk);

    $display("Covered %0d loads, %0d builds, %0d answered and %0d refused queries,",
             loads_done, builds_done, answered, refused);
    $display("%0d dropped words, across %0d element-count settings from one to full depth",
             ignored, count_settings);
    if (fault_count == 0 && awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
